// ===== src/tdts_pkg.sv =====
// Package for the tick-driven task scheduler: sizes, codes, state encoding
// and the structs passed between the top level and the cells. No dependencies.
package tdts_pkg;

   localparam int NUM_TASKS    = 8;
   localparam int COUNTER_BITS = 16;
   localparam int IDX_BITS     = $clog2(NUM_TASKS);

   // fixed field widths of the channels
   localparam int REQ_INDEX_W = 3;
   localparam int FIELD_CNT_W = 16;
   localparam int PRIO_W      = 16;
   localparam int RUN_TASK_W  = 3;

   localparam logic [IDX_BITS-1:0] SCAN_LAST = IDX_BITS'(NUM_TASKS - 1);

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   localparam logic POLICY_SHORTEST = 1'b0;
   localparam logic POLICY_PRIORITY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // best candidate handed down the chain
   typedef struct packed {
      logic                    found;
      logic [IDX_BITS-1:0]     idx;
      logic [COUNTER_BITS-1:0] cnt;
      logic [PRIO_W-1:0]       prio;
   } cand_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                    wr_en;
      logic [IDX_BITS-1:0]     wr_idx;
      logic [COUNTER_BITS-1:0] wr_cnt;
      logic [PRIO_W-1:0]       wr_prio;
      logic                    dec_en;
      logic [IDX_BITS-1:0]     dec_idx;
      logic                    policy;
   } cell_ctrl_type;

endpackage

// ===== src/tdts_req_if.sv =====
// Request channel of the task scheduler: valid/ready plus one request beat.
// Depends on tdts_pkg for field widths.
interface tdts_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [tdts_pkg::REQ_INDEX_W-1:0] task_index;
   logic [tdts_pkg::FIELD_CNT_W-1:0] load_counter;
   logic [tdts_pkg::PRIO_W-1:0]      load_priority;

   modport source (output valid, output req_type, output task_index,
                   output load_counter, output load_priority, input ready);
   modport sink   (input valid, input req_type, input task_index,
                   input load_counter, input load_priority, output ready);
endinterface

// ===== src/tdts_rsp_if.sv =====
// Response channel of the task scheduler: valid/ready plus one result beat.
// Depends on tdts_pkg for field widths.
interface tdts_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tdts_pkg::RUN_TASK_W-1:0]  running_task;
   logic                             switched;
   logic                             reload_request;
   logic [tdts_pkg::FIELD_CNT_W-1:0] running_counter;

   modport source (output valid, output running_task, output switched,
                   output reload_request, output running_counter, input ready);
   modport sink   (input valid, input running_task, input switched,
                   input reload_request, input running_counter, output ready);
endinterface

// ===== src/tdts_cell.sv =====
// One task cell: holds a task's counter and priority and compares its entry
// against the candidate from the previous cell. Depends on tdts_pkg.
module tdts_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tdts_pkg::IDX_BITS-1:0]     cell_index,
   input  tdts_pkg::cell_ctrl_type           ctrl,
   input  tdts_pkg::cand_type                cand_in,
   output tdts_pkg::cand_type                cand_out,
   output logic [tdts_pkg::COUNTER_BITS-1:0] cnt_out
);

   localparam logic [tdts_pkg::COUNTER_BITS-1:0] COUNTER_ONE =
      tdts_pkg::COUNTER_BITS'(1);

   logic [tdts_pkg::COUNTER_BITS-1:0] cnt_ff,  cnt_in;
   logic [tdts_pkg::PRIO_W-1:0]       prio_ff, prio_in;
   tdts_pkg::cand_type                cand_ff, cand_nxt_in;
   logic                              take_own;

   always_comb begin
      cnt_in  = cnt_ff;
      prio_in = prio_ff;
      if (ctrl.wr_en && (ctrl.wr_idx == cell_index)) begin
         cnt_in  = ctrl.wr_cnt;
         prio_in = ctrl.wr_prio;
      end else if (ctrl.dec_en && (ctrl.dec_idx == cell_index)) begin
         cnt_in = cnt_ff - COUNTER_ONE;
      end
   end

   // earlier cells win ties, so replace only on a strict improvement
   always_comb begin
      take_own = 1'b0;
      if (cnt_ff != '0) begin
         if (!cand_in.found) begin
            take_own = 1'b1;
         end else if (ctrl.policy == tdts_pkg::POLICY_SHORTEST) begin
            take_own = (cnt_ff < cand_in.cnt);
         end else begin
            take_own = (prio_ff > cand_in.prio);
         end
      end
      cand_nxt_in = cand_in;
      if (take_own) begin
         cand_nxt_in.found = 1'b1;
         cand_nxt_in.idx   = cell_index;
         cand_nxt_in.cnt   = cnt_ff;
         cand_nxt_in.prio  = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         prio_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         prio_ff <= prio_in;
      end
      cand_ff <= cand_nxt_in;
   end

   assign cand_out = cand_ff;
   assign cnt_out  = cnt_ff;

endmodule

// ===== src/tick_driven_task_scheduler_unit.sv =====
// Top level of the tick-driven task scheduler: sequencer, running-task state,
// result register and the chain of task cells. Depends on tdts_pkg,
// tdts_req_if, tdts_rsp_if and tdts_cell.
//
//   channel   direction  beat contents
//   req_bus   in         req_type, task_index, load_counter, load_priority
//   rsp_bus   out        running_task, switched, reload_request, running_counter
//   csr_*     in         csr_wr_en, csr_wr_data (policy_mode)
//
// A load beat or a tick that only decrements the running task goes from ST_IDLE
// straight to ST_DONE. A tick that schedules walks the best candidate down the
// chain of NUM_TASKS-1 cells, one cell a cycle, in ST_SCAN before ST_DONE. One
// beat is in work at a time; the next is taken once the
// result has moved into the output register, even while that register waits.
// Reset is synchronous and clears every task entry, the running task and the
// policy; a stalled response holds its beat and blocks only the next result.
module tick_driven_task_scheduler_unit (
   input  logic     clock,
   input  logic     reset,
   tdts_req_if.sink   req_bus,
   tdts_rsp_if.source rsp_bus,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data
);

   tdts_pkg::state_type               state_ff, state_in;
   logic [tdts_pkg::IDX_BITS-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [tdts_pkg::IDX_BITS-1:0]     cur_ff, cur_in;
   logic                              sw_ff, sw_in;
   logic                              reload_ff, reload_in;
   logic                              policy_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_load;
   logic [tdts_pkg::RUN_TASK_W-1:0]   rsp_task_ff;
   logic                              rsp_sw_ff;
   logic                              rsp_reload_ff;
   logic [tdts_pkg::FIELD_CNT_W-1:0]  rsp_cnt_ff;

   tdts_pkg::cell_ctrl_type           ctrl;
   tdts_pkg::cand_type                chain [tdts_pkg::NUM_TASKS];
   logic [tdts_pkg::COUNTER_BITS-1:0] cell_cnt [tdts_pkg::NUM_TASKS];
   logic [tdts_pkg::COUNTER_BITS-1:0] cur_cnt;
   logic                              req_accept;
   logic                              load_ok;
   logic [tdts_pkg::IDX_BITS-1:0]     sched_idx;

   // idle task: entry never written, counter stays zero, no candidate
   assign chain[0]    = '0;
   assign cell_cnt[0] = '0;

   for (genvar i = 1; i < tdts_pkg::NUM_TASKS; i++) begin : g_cell
      tdts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (tdts_pkg::IDX_BITS'(i)),
         .ctrl       (ctrl),
         .cand_in    (chain[i-1]),
         .cand_out   (chain[i]),
         .cnt_out    (cell_cnt[i])
      );
   end

   assign cur_cnt    = cell_cnt[cur_ff];
   assign req_accept = req_bus.valid && req_bus.ready;

   // drop loads to the idle task and loads beyond the table
   assign load_ok = (req_bus.task_index != '0) &&
                    (32'(req_bus.task_index) < tdts_pkg::NUM_TASKS);

   // winner at the end of the chain, idle task when no counter is left
   assign sched_idx = chain[tdts_pkg::NUM_TASKS-1].found ?
                      chain[tdts_pkg::NUM_TASKS-1].idx : '0;

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      cur_in       = cur_ff;
      sw_in        = sw_ff;
      reload_in    = reload_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      req_bus.ready = 1'b0;

      ctrl.wr_en   = 1'b0;
      ctrl.wr_idx  = tdts_pkg::IDX_BITS'(req_bus.task_index);
      ctrl.wr_cnt  = tdts_pkg::COUNTER_BITS'(req_bus.load_counter);
      ctrl.wr_prio = req_bus.load_priority;
      ctrl.dec_en  = 1'b0;
      ctrl.dec_idx = cur_ff;
      ctrl.policy  = policy_ff;

      unique case (state_ff)
         tdts_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_accept) begin
               sw_in     = 1'b0;
               reload_in = 1'b0;
               if (req_bus.req_type == tdts_pkg::REQ_LOAD) begin
                  ctrl.wr_en = load_ok;
                  state_in   = tdts_pkg::ST_DONE;
               end else if ((cur_ff != '0) && (cur_cnt != '0)) begin
                  // running task still has time: burn one slice
                  ctrl.dec_en = 1'b1;
                  state_in    = tdts_pkg::ST_DONE;
               end else begin
                  scan_cnt_in = '0;
                  state_in    = tdts_pkg::ST_SCAN;
               end
            end
         end
         tdts_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + tdts_pkg::IDX_BITS'(1);
            if (scan_cnt_ff == tdts_pkg::SCAN_LAST) begin
               // candidate has settled through every cell
               cur_in      = sched_idx;
               sw_in       = (sched_idx != cur_ff);
               reload_in   = !chain[tdts_pkg::NUM_TASKS-1].found;
               scan_cnt_in = scan_cnt_ff;
               state_in    = tdts_pkg::ST_DONE;
            end
         end
         tdts_pkg::ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tdts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdts_pkg::ST_IDLE;
         scan_cnt_ff  <= '0;
         cur_ff       <= '0;
         sw_ff        <= 1'b0;
         reload_ff    <= 1'b0;
         policy_ff    <= tdts_pkg::POLICY_SHORTEST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         cur_ff       <= cur_in;
         sw_ff        <= sw_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_task_ff   <= tdts_pkg::RUN_TASK_W'(cur_ff);
         rsp_sw_ff     <= sw_ff;
         rsp_reload_ff <= reload_ff;
         rsp_cnt_ff    <= tdts_pkg::FIELD_CNT_W'(cur_cnt);
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.running_task    = rsp_task_ff;
   assign rsp_bus.switched        = rsp_sw_ff;
   assign rsp_bus.reload_request  = rsp_reload_ff;
   assign rsp_bus.running_counter = rsp_cnt_ff;

   a_load_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_bus.req_type == tdts_pkg::REQ_LOAD))
         |=> (state_ff == tdts_pkg::ST_DONE))
      else $error("load beat did not go straight to result");

   a_scan_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdts_pkg::ST_SCAN) |-> ($stable(cur_cnt) && $stable(cur_ff)))
      else $error("task state changed during scan");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdts_pkg::ST_SCAN) |-> (scan_cnt_ff <= tdts_pkg::SCAN_LAST))
      else $error("scan counter ran past the chain");

   a_reload_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.reload_request) |-> (rsp_bus.running_task == '0))
      else $error("reload request with a real task running");

   a_dec_keeps: assert property (@(posedge clock) disable iff (reset)
      ctrl.dec_en |=> ($stable(cur_ff) && (state_ff == tdts_pkg::ST_DONE)))
      else $error("decrementing tick changed the running task");

endmodule

// ===== tb/sv/tb_tick_driven_task_scheduler_unit.sv =====
// Self-checking bench for tick_driven_task_scheduler_unit: directed table then
// random phases, each result beat checked against a hand-read result or a local scheduler predictor.
// Depends on tdts_pkg, tdts_req_if, tdts_rsp_if and the scheduler RTL.
`timescale 1ns / 100ps

module tb_tick_driven_task_scheduler_unit;

   localparam int DIRECTED_ROWS  = 24;
   localparam int PHASE_BEATS    = 125;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int END_SETTLE     = 20;

   // one request beat and one result beat, at the channel widths
   typedef struct packed {
      logic                             kind;
      logic [tdts_pkg::REQ_INDEX_W-1:0] index;
      logic [tdts_pkg::FIELD_CNT_W-1:0] count;
      logic [tdts_pkg::PRIO_W-1:0]      prio;
   } sched_req_type;

   typedef struct packed {
      logic [tdts_pkg::RUN_TASK_W-1:0]  running_task;
      logic                             switched;
      logic                             reload_request;
      logic [tdts_pkg::FIELD_CNT_W-1:0] running_counter;
   } sched_result_type;

   // directed row: when typed is set, res holds the result read off by hand
   typedef struct packed {
      sched_req_type    req;
      logic             typed;
      sched_result_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   tdts_req_if req_bus ();
   tdts_rsp_if rsp_bus ();

   tick_driven_task_scheduler_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: task table, running task and policy
   logic [tdts_pkg::COUNTER_BITS-1:0] task_left [tdts_pkg::NUM_TASKS];
   logic [tdts_pkg::PRIO_W-1:0]       task_prio [tdts_pkg::NUM_TASKS];
   int                                running_idx;
   logic                              policy_sel;
   logic                              last_reload;

   sched_result_type due_results [$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int               send_gap_pct = 0;
   int               recv_stall_pct = 0;

   // Tick column first, then load. Rows with typed = 0 take the predictor.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // tick straight after reset: nothing loaded, idle stays, reload raised
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b1,
        '{3'd0, 1'b0, 1'b1, 16'h0000}},
      // load to the idle task is dropped
      '{'{tdts_pkg::REQ_LOAD, 3'd0, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{3'd0, 1'b0, 1'b0, 16'h0000}},
      // top index with full-scale counter and priority
      '{'{tdts_pkg::REQ_LOAD, 3'd7, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{3'd0, 1'b0, 1'b0, 16'h0000}},
      '{'{tdts_pkg::REQ_LOAD, 3'd1, 16'h0003, 16'h0000}, 1'b1,
        '{3'd0, 1'b0, 1'b0, 16'h0000}},
      '{'{tdts_pkg::REQ_LOAD, 3'd2, 16'h0001, 16'h0001}, 1'b1,
        '{3'd0, 1'b0, 1'b0, 16'h0000}},
      // zero counter: never a candidate
      '{'{tdts_pkg::REQ_LOAD, 3'd4, 16'h0000, 16'hAAAA}, 1'b1,
        '{3'd0, 1'b0, 1'b0, 16'h0000}},
      // shortest first picks task 2
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b1,
        '{3'd2, 1'b1, 1'b0, 16'h0001}},
      // decrement to zero, task 2 keeps running until the next tick
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b1,
        '{3'd2, 1'b0, 1'b0, 16'h0000}},
      '{'{tdts_pkg::REQ_LOAD, 3'd3, 16'h0003, 16'h5555}, 1'b0, '0},
      // tie between tasks 1 and 3 goes to the lower index
      '{'{tdts_pkg::REQ_TICK, 3'd7, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      // reload the running task's own entry
      '{'{tdts_pkg::REQ_LOAD, 3'd1, 16'h0001, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_LOAD, 3'd5, 16'h0002, 16'h0001}, 1'b0, '0},
      '{'{tdts_pkg::REQ_LOAD, 3'd6, 16'h0002, 16'h0001}, 1'b0, '0},
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
      // clear every remaining counter, the running task's last
      '{'{tdts_pkg::REQ_LOAD, 3'd7, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_LOAD, 3'd6, 16'h0000, 16'h0000}, 1'b0, '0},
      '{'{tdts_pkg::REQ_LOAD, 3'd5, 16'h0000, 16'h0000}, 1'b0, '0},
      // all zero with a real task running: back to idle, switch and reload
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b1,
        '{3'd0, 1'b1, 1'b1, 16'h0000}},
      // idle again, still all zero: reload without a switch
      '{'{tdts_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000}, 1'b1,
        '{3'd0, 1'b0, 1'b1, 16'h0000}}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Apply one beat to the task table and return the result it gives.
   function automatic sched_result_type advance_scheduler(input sched_req_type r);
      sched_result_type res;
      int               best;
      res  = '0;
      best = 0;
      if (r.kind == tdts_pkg::REQ_LOAD) begin
         if (r.index != 0 && r.index < tdts_pkg::NUM_TASKS) begin
            task_left[r.index] = r.count[tdts_pkg::COUNTER_BITS-1:0];
            task_prio[r.index] = r.prio;
         end
      end else if (running_idx != 0 && task_left[running_idx] != 0) begin
         task_left[running_idx] = task_left[running_idx] - 1'b1;
      end else begin
         // scan real tasks; strict compares keep ties on the lowest index
         for (int i = 1; i < tdts_pkg::NUM_TASKS; i++) begin
            if (task_left[i] != 0) begin
               if (best == 0)
                  best = i;
               else if (policy_sel == tdts_pkg::POLICY_SHORTEST) begin
                  if (task_left[i] < task_left[best])
                     best = i;
               end else if (task_prio[i] > task_prio[best])
                  best = i;
            end
         end
         res.switched       = (best != running_idx);
         res.reload_request = (best == 0);
         running_idx        = best;
      end
      res.running_task    = tdts_pkg::RUN_TASK_W'(running_idx);
      res.running_counter = tdts_pkg::FIELD_CNT_W'(task_left[running_idx]);
      return res;
   endfunction

   // Mostly ticks and small counters so tasks run out and rescheduling is
   // frequent; now and then a full-scale or random counter.
   function automatic sched_req_type random_request();
      sched_req_type r;
      int            sel;
      r.kind  = ($urandom_range(0, 99) < 55) ? tdts_pkg::REQ_TICK : tdts_pkg::REQ_LOAD;
      r.index = tdts_pkg::REQ_INDEX_W'($urandom_range(0, (1 << tdts_pkg::REQ_INDEX_W) - 1));
      sel     = $urandom_range(0, 19);
      if (sel == 0)
         r.count = tdts_pkg::FIELD_CNT_W'($urandom);
      else if (sel == 1)
         r.count = '1;
      else
         r.count = tdts_pkg::FIELD_CNT_W'($urandom_range(0, 6));
      r.prio = ($urandom_range(0, 1) == 0) ? tdts_pkg::PRIO_W'($urandom)
                                           : tdts_pkg::PRIO_W'($urandom_range(0, 3));
      return r;
   endfunction

   // Drive one beat, hold it until accepted, then queue its expected result.
   task automatic send_request(input sched_req_type r, input logic use_typed,
                               input sched_result_type typed_res);
      sched_result_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= r.kind;
      req_bus.task_index    <= r.index;
      req_bus.load_counter  <= r.count;
      req_bus.load_priority <= r.prio;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      predicted   = advance_scheduler(r);
      last_reload = predicted.reload_request;
      due_results.push_back(use_typed ? typed_res : predicted);
   endtask

   // Drop valid and wait for every outstanding result beat.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
   endtask

   // Write the policy only once the block has gone quiet.
   task automatic write_policy(input logic mode);
      drain_results();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      policy_sel   = mode;
   endtask

   // Result side: check each accepted beat, then pick the next ready level.
   always @(posedge clock) begin
      sched_result_type want;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (due_results.size() == 0)
            note_mismatch($sformatf("result beat with nothing expected: task %0d counter %0d",
                                    rsp_bus.running_task, rsp_bus.running_counter));
         else begin
            want = due_results.pop_front();
            if (rsp_bus.running_task !== want.running_task)
               note_mismatch($sformatf("running_task got %0d, expected %0d",
                                       rsp_bus.running_task, want.running_task));
            if (rsp_bus.switched !== want.switched)
               note_mismatch($sformatf("switched got %0b, expected %0b",
                                       rsp_bus.switched, want.switched));
            if (rsp_bus.reload_request !== want.reload_request)
               note_mismatch($sformatf("reload_request got %0b, expected %0b",
                                       rsp_bus.reload_request, want.reload_request));
            if (rsp_bus.running_counter !== want.running_counter)
               note_mismatch($sformatf("running_counter got %0d, expected %0d",
                                       rsp_bus.running_counter, want.running_counter));
         end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      sched_req_type r;
      int            sent;
      int            burst;
      logic          paused;

      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= 1'b0;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= tdts_pkg::REQ_TICK;
      req_bus.task_index    <= '0;
      req_bus.load_counter  <= '0;
      req_bus.load_priority <= '0;

      for (int i = 0; i < tdts_pkg::NUM_TASKS; i++) begin
         task_left[i] = '0;
         task_prio[i] = '0;
      end
      running_idx = 0;
      policy_sel  = tdts_pkg::POLICY_SHORTEST;
      last_reload = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table under the reset policy, sender sparse, receiver busy
      send_gap_pct   = 29;
      recv_stall_pct = 62;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

      // random phases: swap the idling ratios, then run flat out
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct   = 29;
               recv_stall_pct = 62;
            end
            1: begin
               send_gap_pct   = 62;
               recv_stall_pct = 29;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         write_policy((phase == 1) ? tdts_pkg::POLICY_SHORTEST : tdts_pkg::POLICY_PRIORITY);

         sent   = 0;
         paused = 1'b0;
         while (sent < PHASE_BEATS) begin
            // hold off halfway through until the result side has caught up
            if (!paused && sent >= PHASE_BEATS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            if (last_reload) begin
               // table ran dry: refill a handful of real tasks
               burst = $urandom_range(2, tdts_pkg::NUM_TASKS - 1);
               for (int k = 0; k < burst; k++) begin
                  r.kind  = tdts_pkg::REQ_LOAD;
                  r.index = tdts_pkg::REQ_INDEX_W'($urandom_range(1, tdts_pkg::NUM_TASKS - 1));
                  r.count = tdts_pkg::FIELD_CNT_W'($urandom_range(1, 6));
                  r.prio  = tdts_pkg::PRIO_W'($urandom);
                  send_request(r, 1'b0, '0);
                  sent++;
               end
            end else begin
               r = random_request();
               send_request(r, 1'b0, '0);
               // loads to the idle task are dropped by the block
               if (!(r.kind == tdts_pkg::REQ_LOAD && r.index == 0))
                  sent++;
            end
         end
      end

      drain_results();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
